/* hw/rtl/urrl_pkg.sv */
// Shared types, constants and helper functions for the unicycle rollout block.
`timescale 1ns / 1ps
`default_nettype none
package urrl_pkg;

    localparam int MAX_BRAKE_STEPS_DEF = 64;
    localparam int CORDIC_STEPS        = 24;
    localparam int CFG_W               = 24;
    localparam int CFG_IDX_W           = 3;

    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic [29:0]        RAD_TO_PHASE = 30'd683565276;

    // Operation codes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_CONTROL = 2'd1;
    localparam logic [1:0] OP_FINISH  = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_FWD_SPEED  = 3'd0;
    localparam logic [2:0] REG_REV_SPEED  = 3'd1;
    localparam logic [2:0] REG_TURN_RATE  = 3'd2;
    localparam logic [2:0] REG_LIN_ACCEL  = 3'd3;
    localparam logic [2:0] REG_LIN_DECEL  = 3'd4;
    localparam logic [2:0] REG_TURN_ACCEL = 3'd5;
    localparam logic [2:0] REG_STEP_TIME  = 3'd6;
    localparam logic [2:0] REG_HORIZON    = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_BRAKE_CHECK,
        ST_LIMIT,
        ST_VEL,
        ST_PROD,
        ST_MID,
        ST_PHASE,
        ST_CINIT,
        ST_CORDIC,
        ST_CFIX,
        ST_PROJ_LO,
        ST_PROJ_HI,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       start;
        logic       take_dt;
        logic       brake;
        logic       limit;
        logic       vel;
        logic       prod;
        logic       mid;
        logic       phase;
        logic       cinit;
        logic       citer;
        logic [4:0] iter;
        logic       cfix;
        logic       proj_lo;
        logic       proj_hi;
        logic       commit;
        logic       emit;
        logic       emit_new;
        logic       emit_last;
        logic       emit_trunc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic dt_pos;
        logic moving;
        logic out_free;
    } dp_status_t;

    // CORDIC arctangent table, binary angle with 2^32 per turn
    function automatic logic [29:0] atan_lut(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] abs17(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        return v[15] ? 17'(-w) : 17'(w);
    endfunction

    // Move cur toward tgt by at most lim
    function automatic logic signed [15:0] approach(input logic signed [15:0] cur,
                                                    input logic signed [15:0] tgt,
                                                    input logic [16:0] lim);
        logic signed [17:0] d;
        logic signed [17:0] ls;
        logic signed [17:0] r;
        d  = 18'(tgt) - 18'(cur);
        ls = $signed({1'b0, lim});
        if (d > ls) d = ls;
        if (d < -ls) d = -ls;
        r = 18'(cur) + d;
        return r[15:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/urrl_dp.sv */
// Datapath: config registers, rollout state, rate limiter, CORDIC and pose update.
`timescale 1ns / 1ps
`default_nettype none
module urrl_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire urrl_pkg::ctrl_cmd_t               cmd,
    output urrl_pkg::dp_status_t                   status,
    input  wire logic                              cfg_wr_en,
    input  wire logic [urrl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [urrl_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic signed [15:0]                s_lin_vel,
    input  wire logic signed [15:0]                s_ang_vel,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [31:0]                     m_pos_x,
    output logic signed [31:0]                     m_pos_y,
    output logic signed [31:0]                     m_heading,
    output logic signed [15:0]                     m_out_lin_vel,
    output logic signed [15:0]                     m_out_ang_vel,
    output logic                                   m_new_pose,
    output logic                                   m_last,
    output logic                                   m_truncated
);

    // Config registers
    logic [14:0] fwd_reg, rev_reg, turn_reg;
    logic [15:0] lacc_reg, ldec_reg, tacc_reg, step_reg;
    logic [23:0] hor_reg;

    // Rollout state
    logic [31:0]        px_reg, py_reg, hd_reg;
    logic signed [15:0] cl_reg, ca_reg;
    logic [23:0]        el_reg;

    // Step working registers
    logic signed [15:0] inl_reg, ina_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] lt_reg;
    logic [16:0]        liml_reg, lima_reg;
    logic signed [15:0] nl_reg, na_reg;
    logic signed [33:0] pa_reg, pl_reg;
    logic [31:0]        mid_reg, dhd_reg, ph_reg;
    logic signed [33:0] x_reg, y_reg, z_reg, c_reg, s_reg;
    logic               flip_reg;
    logic signed [66:0] accx_reg, accy_reg;
    logic               mv_reg;

    // Combinational helpers
    logic signed [24:0] rem;
    logic [15:0]        dt_sel;
    logic signed [15:0] tl, ta, lt;
    logic               sign_rev;
    logic [15:0]        rate_sel;
    logic [32:0]        lprod, aprod;
    logic signed [16:0] sl, sa;
    logic signed [33:0] dt34;
    logic signed [33:0] pa_rnd14, pa_rnd13;
    logic signed [63:0] pprod;
    logic [31:0]        ph_off, ph_sub;
    logic signed [33:0] cdx, cdy, catan;
    logic signed [66:0] rnd43, xfull, yfull;
    logic signed [15:0] clin, cang;
    logic signed [16:0] fwd_s, rev_s, turn_s;

    // Control step length, clipped to the remaining horizon
    assign rem    = $signed({1'b0, hor_reg}) - $signed({1'b0, el_reg});
    assign dt_sel = (rem < $signed({9'b0, step_reg})) ? rem[15:0] : step_reg;

    assign status.dt_pos   = (rem > 25'sd0) && (step_reg != 16'd0);
    assign status.moving   = (cl_reg != 16'sd0) || (ca_reg != 16'sd0);
    assign status.out_free = !mv_reg || m_ready;

    // Target selection and rate limit products
    assign tl       = cmd.brake ? 16'sd0 : inl_reg;
    assign ta       = cmd.brake ? 16'sd0 : ina_reg;
    assign sign_rev = (cl_reg != 16'sd0) && (tl != 16'sd0) && (cl_reg[15] ^ tl[15]);
    assign lt       = sign_rev ? 16'sd0 : tl;
    assign rate_sel = (urrl_pkg::abs17(lt) >= urrl_pkg::abs17(cl_reg)) ? lacc_reg : ldec_reg;
    assign lprod    = 33'(rate_sel) * 33'(dt_reg) + 33'd32768;
    assign aprod    = 33'(tacc_reg) * 33'(dt_reg) + 33'd32768;

    // Speed sums and angle products
    assign sl       = 17'(cl_reg) + 17'(nl_reg);
    assign sa       = 17'(ca_reg) + 17'(na_reg);
    assign dt34     = $signed({18'b0, dt_reg});
    assign pa_rnd14 = (pa_reg + 34'sd8192) >>> 14;
    assign pa_rnd13 = (pa_reg + 34'sd4096) >>> 13;
    assign pprod    = 64'($signed(mid_reg)) * $signed({34'b0, urrl_pkg::RAD_TO_PHASE});

    // CORDIC helpers
    assign ph_off = ph_reg + 32'h4000_0000;
    assign ph_sub = ph_reg - 32'h8000_0000;
    assign cdx    = y_reg >>> cmd.iter;
    assign cdy    = x_reg >>> cmd.iter;
    assign catan  = $signed({4'b0, urrl_pkg::atan_lut(cmd.iter)});

    // Projection rounding
    assign rnd43 = 67'sd1 <<< 42;
    assign xfull = (accx_reg + rnd43) >>> 43;
    assign yfull = (accy_reg + rnd43) >>> 43;

    // Start clamp
    assign fwd_s = $signed({2'b0, fwd_reg});
    assign rev_s = $signed({2'b0, rev_reg});
    assign turn_s = $signed({2'b0, turn_reg});
    always_comb begin
        clin = inl_reg;
        if (17'(inl_reg) > fwd_s) clin = fwd_s[15:0];
        if (17'(inl_reg) < -rev_s) clin = 16'(-rev_s);
        cang = ina_reg;
        if (17'(ina_reg) > turn_s) cang = turn_s[15:0];
        if (17'(ina_reg) < -turn_s) cang = 16'(-turn_s);
    end

    // Config register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg  <= 15'd4096;
            rev_reg  <= 15'd2048;
            turn_reg <= 15'd4096;
            lacc_reg <= 16'd4096;
            ldec_reg <= 16'd4096;
            tacc_reg <= 16'd4096;
            step_reg <= 16'd6554;
            hor_reg  <= 24'd131072;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                urrl_pkg::REG_FWD_SPEED:  fwd_reg  <= cfg_wdata[14:0];
                urrl_pkg::REG_REV_SPEED:  rev_reg  <= cfg_wdata[14:0];
                urrl_pkg::REG_TURN_RATE:  turn_reg <= cfg_wdata[14:0];
                urrl_pkg::REG_LIN_ACCEL:  lacc_reg <= cfg_wdata[15:0];
                urrl_pkg::REG_LIN_DECEL:  ldec_reg <= cfg_wdata[15:0];
                urrl_pkg::REG_TURN_ACCEL: tacc_reg <= cfg_wdata[15:0];
                urrl_pkg::REG_STEP_TIME:  step_reg <= cfg_wdata[15:0];
                urrl_pkg::REG_HORIZON:    hor_reg  <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // Rollout state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg <= '0;
            py_reg <= '0;
            hd_reg <= '0;
            cl_reg <= '0;
            ca_reg <= '0;
            el_reg <= '0;
        end else if (cmd.start) begin
            px_reg <= '0;
            py_reg <= '0;
            hd_reg <= '0;
            cl_reg <= clin;
            ca_reg <= cang;
            el_reg <= '0;
        end else if (cmd.commit) begin
            px_reg <= px_reg + xfull[31:0];
            py_reg <= py_reg + yfull[31:0];
            hd_reg <= hd_reg + dhd_reg;
            cl_reg <= nl_reg;
            ca_reg <= na_reg;
            if (!cmd.brake) el_reg <= el_reg + 24'(dt_reg);
        end
    end

    // Step working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            inl_reg <= s_lin_vel;
            ina_reg <= s_ang_vel;
        end
        if (cmd.take_dt) dt_reg <= cmd.brake ? step_reg : dt_sel;
        if (cmd.limit) begin
            lt_reg   <= lt;
            liml_reg <= lprod[32:16];
            lima_reg <= aprod[32:16];
        end
        if (cmd.vel) begin
            nl_reg <= urrl_pkg::approach(cl_reg, lt_reg, liml_reg);
            na_reg <= urrl_pkg::approach(ca_reg, ta, lima_reg);
        end
        if (cmd.prod) begin
            pl_reg <= 34'(sl) * dt34;
            pa_reg <= 34'(sa) * dt34;
        end
        if (cmd.mid) begin
            mid_reg <= hd_reg + pa_rnd14[31:0];
            dhd_reg <= pa_rnd13[31:0];
        end
        if (cmd.phase) ph_reg <= pprod[47:16];
        // CORDIC rotation, one iteration per cycle
        if (cmd.cinit) begin
            flip_reg <= ph_off[31];
            z_reg    <= 34'($signed(ph_off[31] ? ph_sub : ph_reg));
            x_reg    <= urrl_pkg::CORDIC_GAIN;
            y_reg    <= '0;
        end else if (cmd.citer) begin
            if (!z_reg[33]) begin
                x_reg <= x_reg - cdx;
                y_reg <= y_reg + cdy;
                z_reg <= z_reg - catan;
            end else begin
                x_reg <= x_reg + cdx;
                y_reg <= y_reg - cdy;
                z_reg <= z_reg + catan;
            end
        end
        if (cmd.cfix) begin
            c_reg <= flip_reg ? -x_reg : x_reg;
            s_reg <= flip_reg ? -y_reg : y_reg;
        end
        // Displacement product in two halves of the path length
        if (cmd.proj_lo) begin
            accx_reg <= $signed({50'b0, pl_reg[16:0]}) * 67'(c_reg);
            accy_reg <= $signed({50'b0, pl_reg[16:0]}) * 67'(s_reg);
        end else if (cmd.proj_hi) begin
            accx_reg <= accx_reg + ((67'($signed(pl_reg[33:17])) * 67'(c_reg)) <<< 17);
            accy_reg <= accy_reg + ((67'($signed(pl_reg[33:17])) * 67'(s_reg)) <<< 17);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.emit) begin
            mv_reg <= 1'b1;
        end else if (m_ready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_pos_x       <= px_reg;
            m_pos_y       <= py_reg;
            m_heading     <= hd_reg;
            m_out_lin_vel <= cl_reg;
            m_out_ang_vel <= ca_reg;
            m_new_pose    <= cmd.emit_new;
            m_last        <= cmd.emit_last;
            m_truncated   <= cmd.emit_trunc;
        end
    end

    assign m_valid = mv_reg;

endmodule
`default_nettype wire

/* hw/rtl/urrl_ctrl.sv */
// Controller: sequences start, control and braking steps through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module urrl_ctrl #(
    parameter int MAX_BRAKE_STEPS = urrl_pkg::MAX_BRAKE_STEPS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_op,
    input  wire urrl_pkg::dp_status_t status,
    output urrl_pkg::ctrl_cmd_t       cmd
);

    localparam int CW = $clog2(MAX_BRAKE_STEPS + 1);

    urrl_pkg::state_t state_reg, state_next;
    logic [4:0]       iter_reg, iter_next;
    logic             brake_reg, brake_next;
    logic             stop_reg, stop_next;
    logic [CW-1:0]    n_reg, n_next;
    logic             is_last;

    assign is_last = brake_reg &&
                     ((CW'(n_reg + 1'b1) == CW'(MAX_BRAKE_STEPS)) || !status.moving);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= urrl_pkg::ST_IDLE;
            iter_reg  <= '0;
            brake_reg <= 1'b0;
            stop_reg  <= 1'b0;
            n_reg     <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            brake_reg <= brake_next;
            stop_reg  <= stop_next;
            n_reg     <= n_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        brake_next = brake_reg;
        stop_next  = stop_reg;
        n_next     = n_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.brake  = brake_reg;
        cmd.iter   = iter_reg;
        case (state_reg)
            urrl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    stop_next   = 1'b0;
                    n_next      = '0;
                    case (s_op)
                        urrl_pkg::OP_START: begin
                            brake_next = 1'b0;
                            state_next = urrl_pkg::ST_START;
                        end
                        urrl_pkg::OP_CONTROL: begin
                            brake_next = 1'b0;
                            state_next = urrl_pkg::ST_CHECK;
                        end
                        urrl_pkg::OP_FINISH: begin
                            brake_next = 1'b1;
                            state_next = urrl_pkg::ST_BRAKE_CHECK;
                        end
                        default: state_next = urrl_pkg::ST_IDLE;
                    endcase
                end
            end
            urrl_pkg::ST_START: begin
                cmd.start  = 1'b1;
                state_next = urrl_pkg::ST_EMIT;
            end
            urrl_pkg::ST_CHECK: begin
                cmd.take_dt = 1'b1;
                state_next  = status.dt_pos ? urrl_pkg::ST_LIMIT : urrl_pkg::ST_IDLE;
            end
            urrl_pkg::ST_BRAKE_CHECK: begin
                cmd.take_dt = 1'b1;
                if (status.moving) begin
                    state_next = urrl_pkg::ST_LIMIT;
                end else begin
                    stop_next  = 1'b1;
                    state_next = urrl_pkg::ST_EMIT;
                end
            end
            urrl_pkg::ST_LIMIT: begin
                cmd.limit  = 1'b1;
                state_next = urrl_pkg::ST_VEL;
            end
            urrl_pkg::ST_VEL: begin
                cmd.vel    = 1'b1;
                state_next = urrl_pkg::ST_PROD;
            end
            urrl_pkg::ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = urrl_pkg::ST_MID;
            end
            urrl_pkg::ST_MID: begin
                cmd.mid    = 1'b1;
                state_next = urrl_pkg::ST_PHASE;
            end
            urrl_pkg::ST_PHASE: begin
                cmd.phase  = 1'b1;
                state_next = urrl_pkg::ST_CINIT;
            end
            urrl_pkg::ST_CINIT: begin
                cmd.cinit  = 1'b1;
                iter_next  = '0;
                state_next = urrl_pkg::ST_CORDIC;
            end
            urrl_pkg::ST_CORDIC: begin
                cmd.citer = 1'b1;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(urrl_pkg::CORDIC_STEPS - 1)) begin
                    state_next = urrl_pkg::ST_CFIX;
                end
            end
            urrl_pkg::ST_CFIX: begin
                cmd.cfix   = 1'b1;
                state_next = urrl_pkg::ST_PROJ_LO;
            end
            urrl_pkg::ST_PROJ_LO: begin
                cmd.proj_lo = 1'b1;
                state_next  = urrl_pkg::ST_PROJ_HI;
            end
            urrl_pkg::ST_PROJ_HI: begin
                cmd.proj_hi = 1'b1;
                state_next  = urrl_pkg::ST_COMMIT;
            end
            urrl_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = urrl_pkg::ST_EMIT;
            end
            urrl_pkg::ST_EMIT: begin
                // Wait for the output register to free up
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (stop_reg) begin
                        cmd.emit_last = 1'b1;
                        state_next    = urrl_pkg::ST_IDLE;
                    end else begin
                        cmd.emit_new   = 1'b1;
                        cmd.emit_last  = is_last;
                        cmd.emit_trunc = is_last && status.moving;
                        if (brake_reg && !is_last) begin
                            n_next     = CW'(n_reg + 1'b1);
                            state_next = urrl_pkg::ST_LIMIT;
                        end else begin
                            state_next = urrl_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = urrl_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/unicycle_rollout_rate_limited.sv */
// A start item gives its result from the emit state; a control step passes the full datapath first.
// A new item is taken only in idle, once the last one, with its 24-iteration CORDIC, is done.
// A braking item yields up to MAX_BRAKE_STEPS results, each a full step through the datapath.
// Reset (aresetn low, synchronous) restores register defaults and zeroes pose and velocities.
// Top level: unicycle rollout with rate-limited velocities.
`timescale 1ns / 1ps
`default_nettype none
module unicycle_rollout_rate_limited #(
    parameter int MAX_BRAKE_STEPS = urrl_pkg::MAX_BRAKE_STEPS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [urrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [urrl_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_op,
    input  wire logic signed [15:0]             s_lin_vel,
    input  wire logic signed [15:0]             s_ang_vel,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [31:0]                  m_pos_x,
    output logic signed [31:0]                  m_pos_y,
    output logic signed [31:0]                  m_heading,
    output logic signed [15:0]                  m_out_lin_vel,
    output logic signed [15:0]                  m_out_ang_vel,
    output logic                                m_new_pose,
    output logic                                m_last,
    output logic                                m_truncated
);

    urrl_pkg::ctrl_cmd_t  cmd;
    urrl_pkg::dp_status_t status;

    urrl_ctrl #(
        .MAX_BRAKE_STEPS(MAX_BRAKE_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .status  (status),
        .cmd     (cmd)
    );

    urrl_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_lin_vel     (s_lin_vel),
        .s_ang_vel     (s_ang_vel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_heading     (m_heading),
        .m_out_lin_vel (m_out_lin_vel),
        .m_out_ang_vel (m_out_ang_vel),
        .m_new_pose    (m_new_pose),
        .m_last        (m_last),
        .m_truncated   (m_truncated)
    );

endmodule
`default_nettype wire

/* hw/rtl/urrl_checker.sv */
// Port-level checker for the rollout block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module urrl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_pos_x,
    input wire logic        m_new_pose,
    input wire logic        m_last,
    input wire logic        m_truncated
);

    // Held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x))
        else $error("result changed while stalled");

    // Truncation only flags the end of a braking tail
    a_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_last)
        else $error("truncated without last");

    // A repeated pose only closes a tail
    a_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_new_pose |-> m_last && !m_truncated)
        else $error("repeat pose without last");

    // A waiting input item stays offered until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input item withdrawn before accept");

endmodule

bind unicycle_rollout_rate_limited urrl_checker u_urrl_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_pos_x     (m_pos_x),
    .m_new_pose  (m_new_pose),
    .m_last      (m_last),
    .m_truncated (m_truncated)
);
`default_nettype wire

/* dv/tb_unicycle_rollout_rate_limited.sv */
// Self-checking testbench for the unicycle rollout block: directed table, then random phases.
`timescale 1ns / 1ps
module tb_unicycle_rollout_rate_limited;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         SETTLE      = 80;
    localparam int         N_REGS      = 8;
    localparam int         BRAKE_CAP   = urrl_pkg::MAX_BRAKE_STEPS_DEF;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic [15:0] lin;
        logic [15:0] ang;
        logic        new_pose;
        logic        last;
        logic        truncated;
    } pose_t;

    typedef struct {
        logic        is_cfg;
        logic [2:0]  idx;
        logic [23:0] val;
        logic [1:0]  op;
        logic [15:0] lv;
        logic [15:0] av;
        logic        typed;
        pose_t       res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [urrl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [urrl_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_op = urrl_pkg::OP_START;
    logic signed [15:0] s_lin_vel = '0;
    logic signed [15:0] s_ang_vel = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_heading;
    logic signed [15:0] m_out_lin_vel, m_out_ang_vel;
    logic m_new_pose, m_last, m_truncated;

    // typed expectation travels with the item like payload
    logic  typed_use = 1'b0;
    pose_t typed_res = '0;

    unicycle_rollout_rate_limited DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_lin_vel(s_lin_vel), .s_ang_vel(s_ang_vel),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pos_x(m_pos_x), .m_pos_y(m_pos_y), .m_heading(m_heading),
        .m_out_lin_vel(m_out_lin_vel), .m_out_ang_vel(m_out_ang_vel),
        .m_new_pose(m_new_pose), .m_last(m_last), .m_truncated(m_truncated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- predictor ----------------
    longint unsigned lim_reg [N_REGS];
    logic [31:0] px, py, hdg;
    longint      vlin, vang, t_used;
    pose_t       pose_q[$];
    int          mismatches = 0;
    longint      cycles = 0;

    function automatic void enqueue_pose(pose_t p);
        pose_q = {pose_q, p};
    endfunction

    function automatic longint rnd_shr(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint step_toward(longint cur, longint tgt, longint rate, longint dt);
        longint lim, d;
        lim = (rate * dt + 32768) >>> 16;
        d = tgt - cur;
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        return cur + d;
    endfunction

    task automatic sin_cos(input logic [31:0] phase, output longint c, output longint s);
        logic [31:0] p;
        logic        flip;
        longint      x, y, z, dx, dy;
        p = phase + 32'h4000_0000;
        flip = p[31];
        p = flip ? phase - 32'h8000_0000 : phase;
        z = longint'($signed(p));
        x = urrl_pkg::CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < urrl_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(urrl_pkg::atan_lut(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(urrl_pkg::atan_lut(5'(i)));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // one midpoint-heading integration step
    task automatic integrate(input longint tl, input longint ta, input longint dt);
        longint lt, al, ac, rate, nl, na, pa, pl, c, s;
        logic [31:0] mid;
        logic [63:0] ph;
        lt = (vlin * tl < 0) ? 0 : tl;
        al = lt < 0 ? -lt : lt;
        ac = vlin < 0 ? -vlin : vlin;
        rate = (al >= ac) ? lim_reg[urrl_pkg::REG_LIN_ACCEL] : lim_reg[urrl_pkg::REG_LIN_DECEL];
        nl = step_toward(vlin, lt, rate, dt);
        na = step_toward(vang, ta, lim_reg[urrl_pkg::REG_TURN_ACCEL], dt);
        pa = (vang + na) * dt;
        pl = (vlin + nl) * dt;
        mid = hdg + 32'(rnd_shr(pa, 14));
        ph = 64'(longint'($signed(mid))) * 64'(urrl_pkg::RAD_TO_PHASE);
        sin_cos(ph[47:16], c, s);
        px += 32'(rnd_shr(pl * c, 43));
        py += 32'(rnd_shr(pl * s, 43));
        hdg += 32'(rnd_shr(pa, 13));
        vlin = nl;
        vang = na;
    endtask

    function automatic pose_t cur_pose(logic np, logic lst, logic tr);
        pose_t p;
        p = '{px, py, hdg, 16'(vlin), 16'(vang), np, lst, tr};
        return p;
    endfunction

    task automatic predict_item(input logic [1:0] op, input logic signed [15:0] lv,
                                input logic signed [15:0] av);
        longint l, a, dt, rem, fwd, rev, turn;
        int     n;
        pose_t  p;
        l = lv;
        a = av;
        fwd  = longint'(lim_reg[urrl_pkg::REG_FWD_SPEED]);
        rev  = longint'(lim_reg[urrl_pkg::REG_REV_SPEED]);
        turn = longint'(lim_reg[urrl_pkg::REG_TURN_RATE]);
        case (op)
            urrl_pkg::OP_START: begin
                if (l > fwd) l = fwd;
                if (l < -rev) l = -rev;
                if (a > turn) a = turn;
                if (a < -turn) a = -turn;
                vlin = l; vang = a;
                px = 0; py = 0; hdg = 0; t_used = 0;
                enqueue_pose(cur_pose(1'b1, 1'b0, 1'b0));
            end
            urrl_pkg::OP_CONTROL: begin
                dt = lim_reg[urrl_pkg::REG_STEP_TIME];
                rem = longint'(lim_reg[urrl_pkg::REG_HORIZON]) - t_used;
                if (rem < dt) dt = rem;
                if (dt > 0) begin
                    integrate(l, a, dt);
                    t_used += dt;
                    enqueue_pose(cur_pose(1'b1, 1'b0, 1'b0));
                end
            end
            urrl_pkg::OP_FINISH: begin
                n = 0;
                while (n < BRAKE_CAP && (vlin != 0 || vang != 0)) begin
                    integrate(0, 0, lim_reg[urrl_pkg::REG_STEP_TIME]);
                    enqueue_pose(cur_pose(1'b1, 1'b0, 1'b0));
                    n++;
                end
                if (n == 0) begin
                    enqueue_pose(cur_pose(1'b0, 1'b1, 1'b0));
                end else begin
                    p = pose_q[$];
                    p.last = 1'b1;
                    p.truncated = (vlin != 0 || vang != 0);
                    pose_q[pose_q.size() - 1] = p;
                end
            end
            default: ;
        endcase
    endtask

    // ---------------- monitor and checker ----------------
    always @(posedge aclk) begin
        pose_t got, want;
        int    n0;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    urrl_pkg::REG_FWD_SPEED, urrl_pkg::REG_REV_SPEED,
                    urrl_pkg::REG_TURN_RATE:
                        lim_reg[cfg_index] = cfg_wdata[14:0];
                    urrl_pkg::REG_HORIZON: lim_reg[cfg_index] = cfg_wdata[23:0];
                    default: lim_reg[cfg_index] = cfg_wdata[15:0];
                endcase
            end
            if (s_valid && s_ready) begin
                n0 = pose_q.size();
                predict_item(s_op, s_lin_vel, s_ang_vel);
                if (typed_use) begin
                    while (pose_q.size() > n0) void'(pose_q.pop_back());
                    enqueue_pose(typed_res);
                end
            end
            if (m_valid && m_ready) begin
                got = '{m_pos_x, m_pos_y, m_heading, m_out_lin_vel, m_out_ang_vel,
                        m_new_pose, m_last, m_truncated};
                if (pose_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected pose x=%0d y=%0d hdg=%0d",
                                 m_pos_x, m_pos_y, m_heading);
                end else begin
                    want = pose_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: pose mismatch exp x=%0d y=%0d h=%0d v=%0d w=%0d",
                                     $signed(want.pos_x), $signed(want.pos_y),
                                     $signed(want.heading), $signed(want.lin),
                                     $signed(want.ang),
                                     " np=%b l=%b t=%b", want.new_pose, want.last,
                                     want.truncated,
                                     " | got x=%0d y=%0d h=%0d v=%0d w=%0d",
                                     m_pos_x, m_pos_y, m_heading,
                                     m_out_lin_vel, m_out_ang_vel,
                                     " np=%b l=%b t=%b", m_new_pose, m_last,
                                     m_truncated);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- receiver ----------------
    int hold_left = 0;
    bit hold_req = 0;
    int rx_cnt = 0;

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = 600;
            hold_req = 0;
        end
        rx_cnt++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case ((rx_cnt / 97) % 3)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 9) < 6);
                default: m_ready <= (rx_cnt % 5 != 0);
            endcase
        end
    end

    // ---------------- sender ----------------
    int  burst_left = 0;
    bit  no_gaps = 0;

    task automatic send_item(input logic [1:0] op, input logic [15:0] lv,
                             input logic [15:0] av, input logic typed, input pose_t res);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_op <= op;
        s_lin_vel <= lv;
        s_ang_vel <= av;
        typed_use <= typed;
        typed_res <= res;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send(input logic [1:0] op, input logic [15:0] lv, input logic [15:0] av);
        send_item(op, lv, av, 1'b0, '0);
    endtask

    // idle point: all results back, plus a margin for steps that emit nothing
    task automatic drain();
        s_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // one write, then the config port goes idle again
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 8000)) - 4000);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    row_t rows[$];

    function automatic void add_item(logic [1:0] op, logic [15:0] lv, logic [15:0] av);
        rows = {rows, row_t'{1'b0, 3'd0, 24'd0, op, lv, av, 1'b0, pose_t'(0)}};
    endfunction

    function automatic void add_typed(logic [1:0] op, logic [15:0] lv, logic [15:0] av,
                                      pose_t res);
        rows = {rows, row_t'{1'b0, 3'd0, 24'd0, op, lv, av, 1'b1, res}};
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [23:0] val);
        rows = {rows, row_t'{1'b1, idx, val, urrl_pkg::OP_START, 16'd0, 16'd0, 1'b0,
                             pose_t'(0)}};
    endfunction

    initial begin
        logic [23:0] cfg_set [N_REGS];
        logic [23:0] stp;
        int          nctl;
        lim_reg = '{4096, 2048, 4096, 4096, 4096, 4096, 6554, 131072};
        px = 0; py = 0; hdg = 0; vlin = 0; vang = 0; t_used = 0;

        // directed table at register defaults
        add_typed(urrl_pkg::OP_FINISH, 16'd0, 16'd0,
                  '{0, 0, 0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0});
        add_item(OP_UNUSED, 16'hffff, 16'hffff);
        add_typed(urrl_pkg::OP_START, 16'h7fff, 16'h8000,
                  '{0, 0, 0, 16'd4096, -16'sd4096, 1'b1, 1'b0, 1'b0});
        add_typed(urrl_pkg::OP_START, 16'h8000, 16'h7fff,
                  '{0, 0, 0, -16'sd2048, 16'd4096, 1'b1, 1'b0, 1'b0});
        add_item(urrl_pkg::OP_CONTROL, 16'h7fff, 16'h7fff);
        add_item(urrl_pkg::OP_CONTROL, 16'h8000, 16'h8000);
        add_item(urrl_pkg::OP_CONTROL, 16'd0, 16'd0);
        add_item(urrl_pkg::OP_FINISH, 16'd0, 16'd0);
        add_item(urrl_pkg::OP_FINISH, 16'd0, 16'd0);
        add_typed(urrl_pkg::OP_START, 16'd0, 16'd0,
                  '{0, 0, 0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0});
        add_item(urrl_pkg::OP_CONTROL, 16'd3000, -16'sd3000);
        // horizon spent after two steps
        add_cfg(urrl_pkg::REG_HORIZON, 24'd13108);
        add_typed(urrl_pkg::OP_START, 16'd2000, 16'd1000,
                  '{0, 0, 0, 16'd2000, 16'd1000, 1'b1, 1'b0, 1'b0});
        add_item(urrl_pkg::OP_CONTROL, 16'd4000, 16'd4000);
        add_item(urrl_pkg::OP_CONTROL, 16'd4000, 16'd4000);
        add_item(urrl_pkg::OP_CONTROL, 16'd4000, 16'd4000);
        // slow braking hits the step cap
        add_cfg(urrl_pkg::REG_LIN_DECEL, 24'd1);
        add_cfg(urrl_pkg::REG_TURN_ACCEL, 24'd1);
        add_cfg(urrl_pkg::REG_STEP_TIME, 24'd1);
        add_item(urrl_pkg::OP_START, 16'd4096, 16'd4096);
        add_item(urrl_pkg::OP_FINISH, 16'd0, 16'd0);
        // zero acceleration holds the speed
        add_cfg(urrl_pkg::REG_LIN_ACCEL, 24'd0);
        add_cfg(urrl_pkg::REG_STEP_TIME, 24'd6554);
        add_cfg(urrl_pkg::REG_HORIZON, 24'd131072);
        add_item(urrl_pkg::OP_START, 16'd0, 16'd0);
        add_item(urrl_pkg::OP_CONTROL, 16'd1000, 16'd0);
        add_item(OP_UNUSED, 16'd0, 16'd0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                drain();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_item(rows[i].op, rows[i].lv, rows[i].av, rows[i].typed, rows[i].res);
            end
        end
        typed_use <= 1'b0;

        // random phases; the first two are the extremes
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            if (ph == 0) begin
                cfg_set = '{24'd32767, 24'd32767, 24'd32767, 24'd65535,
                            24'd65535, 24'd65535, 24'd65535, 24'hffffff};
            end else if (ph == 1) begin
                cfg_set = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd1, 24'd1, 24'd0};
            end else begin
                stp = $urandom_range(0, 1) ? 24'($urandom_range(1, 65535))
                                           : 24'($urandom_range(500, 8000));
                cfg_set[urrl_pkg::REG_FWD_SPEED]  = 24'($urandom_range(0, 32767));
                cfg_set[urrl_pkg::REG_REV_SPEED]  = 24'($urandom_range(0, 32767));
                cfg_set[urrl_pkg::REG_TURN_RATE]  = 24'($urandom_range(0, 32767));
                cfg_set[urrl_pkg::REG_LIN_ACCEL]  = 24'($urandom_range(0, 65535));
                cfg_set[urrl_pkg::REG_LIN_DECEL]  = 24'($urandom_range(1, 65535));
                cfg_set[urrl_pkg::REG_TURN_ACCEL] = 24'($urandom_range(1, 65535));
                cfg_set[urrl_pkg::REG_STEP_TIME]  = stp;
                cfg_set[urrl_pkg::REG_HORIZON]    = 24'(stp * $urandom_range(2, 30));
            end
            for (int r = 0; r < N_REGS; r++) write_reg(3'(r), cfg_set[r]);

            // long receiver hold while items keep coming
            if (ph == 3) begin
                hold_req = 1;
                no_gaps = 1;
            end
            for (int sq = 0; sq < (ph == 1 ? 2 : 5); sq++) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 6))
                        send(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
                end
                send(urrl_pkg::OP_START, rand_vel(), rand_vel());
                nctl = $urandom_range(1, 10);
                for (int k = 0; k < nctl; k++)
                    send(urrl_pkg::OP_CONTROL, rand_vel(), rand_vel());
                if ($urandom_range(0, 5) != 0)
                    send(urrl_pkg::OP_FINISH, 16'($urandom), 16'($urandom));
            end
            no_gaps = 0;
        end

        drain();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
